### rtl/rgbpal_pkg.sv
// ----------------------------------------------------------------------------
// rgbpal_pkg
// Shared types and constants for the RGB888 to BGR555 palette indexer.
// ----------------------------------------------------------------------------
package rgbpal_pkg;

  localparam int unsigned CHAN_W  = 8;
  localparam int unsigned FIELD_W = 5;
  localparam int unsigned COLOR_W = 15;
  localparam int unsigned INDEX_W = 8;

  typedef struct packed {
    logic              first_pixel;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] red;
  } pixel_t;

  typedef struct packed {
    logic [INDEX_W-1:0] color_index;
    logic               new_entry;
    logic [COLOR_W-1:0] packed_color;
    logic               overflow;
  } result_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } seq_state_t;

  // Keep the top FIELD_W bits of each channel; blue high, red low.
  function automatic logic [COLOR_W-1:0] pack_bgr555(input pixel_t px);
    pack_bgr555 = {px.blue[CHAN_W-1 -: FIELD_W],
                   px.green[CHAN_W-1 -: FIELD_W],
                   px.red[CHAN_W-1 -: FIELD_W]};
  endfunction

endpackage

### rtl/rgbpal_chan_if.sv
// ----------------------------------------------------------------------------
// rgbpal_chan_if
// Valid/ready channel carrying one payload per request.
// ----------------------------------------------------------------------------
interface rgbpal_chan_if #(
  parameter type payload_t = logic
);

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

### rtl/rgb888_to_bgr555_palette_indexer.sv
// ----------------------------------------------------------------------------
// rgb888_to_bgr555_palette_indexer
// Maps RGB888 pixels to BGR555 palette indices, building the palette on the fly.
// ----------------------------------------------------------------------------
// Usage:
//   pixel  : sink channel, one request per pixel (first_pixel, blue, green, red).
//            first_pixel empties the palette before that pixel is handled.
//   result : source channel, one request per pixel (color_index, new_entry,
//            packed_color, overflow). A colour not present when the palette
//            already holds PALETTE_DEPTH entries returns index 0 with overflow.
// Timing:
//   A pixel is searched against the stored entries one per cycle through a
//   single comparator fed by the palette RAM's one read port. The search
//   ends at the first match or after the last stored entry; the result is
//   then registered and handed to the output register, and only then is the
//   next pixel taken. Only one pixel is searched at a time.
// Reset clears the entry count, so the palette starts empty; the RAM is not
// cleared. A stalled result sits in the output register; the next pixel is
// still taken and searched, and its result waits until that register frees.
// ----------------------------------------------------------------------------
module rgb888_to_bgr555_palette_indexer
  import rgbpal_pkg::*;
#(
  parameter int unsigned PALETTE_DEPTH = 256
) (
  input logic         clk,
  input logic         rst,
  rgbpal_chan_if.sink   pixel,
  rgbpal_chan_if.source result
);

  localparam int unsigned IDXW = $clog2(PALETTE_DEPTH);

  logic               seq_ready;
  logic               res_valid;
  logic               slot_free;
  result_t            res;
  logic               wr_en;
  logic [IDXW-1:0]    wr_addr;
  logic [COLOR_W-1:0] wr_data;
  logic               rd_en;
  logic [IDXW-1:0]    rd_addr;
  logic [COLOR_W-1:0] rd_data;
  logic               out_valid;
  result_t            out_data;

  assign slot_free   = !out_valid || result.ready;
  assign pixel.ready = seq_ready;

  rgbpal_seq #(
    .DEPTH (PALETTE_DEPTH)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (pixel.valid),
    .in_ready    (seq_ready),
    .in_pixel    (pixel.payload),
    .res_valid   (res_valid),
    .res_ready   (slot_free),
    .res         (res),
    .mem_wr_en   (wr_en),
    .mem_wr_addr (wr_addr),
    .mem_wr_data (wr_data),
    .mem_rd_en   (rd_en),
    .mem_rd_addr (rd_addr),
    .mem_rd_data (rd_data)
  );

  rgbpal_mem #(
    .DEPTH (PALETTE_DEPTH)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && slot_free) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && slot_free) begin
      out_data <= res;
    end
  end

  assign result.valid   = out_valid;
  assign result.payload = out_data;

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> !(result.payload.new_entry && result.payload.overflow))
    else $error("new_entry and overflow both set");

  a_overflow_index: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.payload.overflow) |-> (result.payload.color_index == '0))
    else $error("overflow with non-zero index");

  a_busy_after_request: assert property (@(posedge clk) disable iff (rst)
    (pixel.valid && pixel.ready) |=> !pixel.ready)
    else $error("pixel taken while a search is running");

  a_handoff: assert property (@(posedge clk) disable iff (rst)
    (res_valid && slot_free) |=> (result.valid && !res_valid))
    else $error("result lost between sequencer and output register");

endmodule

### rtl/rgbpal_mem.sv
// ----------------------------------------------------------------------------
// rgbpal_mem
// Palette store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module rgbpal_mem
  import rgbpal_pkg::*;
#(
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [COLOR_W-1:0]       wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [COLOR_W-1:0]       rd_data
);

  logic [COLOR_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/rgbpal_seq.sv
// ----------------------------------------------------------------------------
// rgbpal_seq
// Search sequencer: walks the palette one entry per cycle via one comparator,
// then returns the hit index, or appends or flags overflow, and hands it on.
// ----------------------------------------------------------------------------
module rgbpal_seq
  import rgbpal_pkg::*;
#(
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  pixel_t                   in_pixel,
  output logic                     res_valid,
  input  logic                     res_ready,
  output result_t                  res,
  output logic                     mem_wr_en,
  output logic [$clog2(DEPTH)-1:0] mem_wr_addr,
  output logic [COLOR_W-1:0]       mem_wr_data,
  output logic                     mem_rd_en,
  output logic [$clog2(DEPTH)-1:0] mem_rd_addr,
  input  logic [COLOR_W-1:0]       mem_rd_data
);

  localparam int unsigned IDXW = $clog2(DEPTH);
  localparam int unsigned CNTW = $clog2(DEPTH + 1);

  seq_state_t         state;
  seq_state_t         state_next;
  logic [COLOR_W-1:0] color;
  logic [CNTW-1:0]    count;
  logic [CNTW-1:0]    scan_idx;
  logic               cmp_valid;
  logic [IDXW-1:0]    cmp_idx;
  result_t            res_q;

  logic accept;
  logic issue;
  logic match;
  logic finish;
  logic full;

  assign accept = in_valid && in_ready;
  assign issue  = (state == ST_SCAN) && (scan_idx < count);
  assign match  = cmp_valid && (mem_rd_data == color);
  // Match, or no compare pending and nothing left to read (colour absent)
  assign finish = (state == ST_SCAN) && (match || (!issue && !cmp_valid));
  assign full   = (count == CNTW'(DEPTH));

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_valid)  state_next = ST_SCAN;
      ST_SCAN: if (finish)    state_next = ST_DONE;
      ST_DONE: if (res_ready) state_next = ST_IDLE;
      default:                state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = (state == ST_IDLE);
    res_valid   = (state == ST_DONE);
    res         = res_q;
    mem_rd_en   = issue;
    mem_rd_addr = scan_idx[IDXW-1:0];
    mem_wr_en   = finish && !match && !full;
    mem_wr_addr = count[IDXW-1:0];
    mem_wr_data = color;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      cmp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        color     <= pack_bgr555(in_pixel);
        scan_idx  <= '0;
        cmp_valid <= 1'b0;
        if (in_pixel.first_pixel) begin
          count <= '0;
        end
      end else if (state == ST_SCAN) begin
        cmp_valid <= issue && !finish;
        cmp_idx   <= scan_idx[IDXW-1:0];
        if (issue) begin
          scan_idx <= scan_idx + 1'b1;
        end
        if (finish) begin
          res_q.packed_color <= color;
          priority if (match) begin
            res_q.color_index <= INDEX_W'(cmp_idx);
            res_q.new_entry   <= 1'b0;
            res_q.overflow    <= 1'b0;
          end else if (!full) begin
            res_q.color_index <= INDEX_W'(count[IDXW-1:0]);
            res_q.new_entry   <= 1'b1;
            res_q.overflow    <= 1'b0;
            count             <= count + 1'b1;
          end else begin
            res_q.color_index <= '0;
            res_q.new_entry   <= 1'b0;
            res_q.overflow    <= 1'b1;
          end
        end
      end
    end
  end

endmodule

### verif/rgbpal_palette_checker.sv
// ----------------------------------------------------------------------------
// rgbpal_palette_checker
// Watches the pixel and result channels, keeps its own copy of the palette,
// works out the index, new-entry and overflow marks of every accepted pixel
// and compares them in order against the accepted results.
// ----------------------------------------------------------------------------
module rgbpal_palette_checker
  import rgbpal_pkg::*;
#(
  parameter int unsigned PALETTE_DEPTH = 256
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    pixel_valid,
  input  logic    pixel_ready,
  input  pixel_t  pixel_payload,
  input  logic    result_valid,
  input  logic    result_ready,
  input  result_t result_payload,
  output int      mismatches,
  output int      outstanding
);

  timeunit 1ns;
  timeprecision 1ps;

  logic [COLOR_W-1:0] palette_colors [PALETTE_DEPTH];
  int unsigned        colors_stored;
  result_t            expected_indices [$];
  int                 fail_total = 0;

  assign mismatches = fail_total;

  // Look the pixel's colour up in the palette copy, appending it when absent.
  function automatic result_t index_pixel(input pixel_t px);
    result_t            res;
    logic [COLOR_W-1:0] color;
    bit                 hit;
    int unsigned        slot;
    if (px.first_pixel) begin
      colors_stored = 0;
    end
    color = {px.blue[CHAN_W-1 -: FIELD_W], px.green[CHAN_W-1 -: FIELD_W],
             px.red[CHAN_W-1 -: FIELD_W]};
    hit  = 1'b0;
    slot = 0;
    for (int unsigned i = 0; i < colors_stored && !hit; i++) begin
      if (palette_colors[i] == color) begin
        hit  = 1'b1;
        slot = i;
      end
    end
    res.packed_color = color;
    res.new_entry    = 1'b0;
    res.overflow     = 1'b0;
    if (!hit) begin
      if (colors_stored < PALETTE_DEPTH) begin
        slot                 = colors_stored;
        palette_colors[slot] = color;
        colors_stored++;
        res.new_entry        = 1'b1;
      end else begin
        slot         = 0;
        res.overflow = 1'b1;
      end
    end
    res.color_index = slot[INDEX_W-1:0];
    return res;
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      colors_stored = 0;
    end else begin
      if (pixel_valid && pixel_ready) begin
        expected_indices.insert(expected_indices.size(), index_pixel(pixel_payload));
      end
      if (result_valid && result_ready) begin
        if (expected_indices.size() == 0) begin
          fail_total++;
          if (fail_total <= 10) begin
            $display("%0t: result request with nothing pending: index %0d colour %h",
                     $realtime, result_payload.color_index, result_payload.packed_color);
          end
        end else begin
          want = expected_indices.pop_front();
          if (result_payload.color_index  !== want.color_index  ||
              result_payload.new_entry    !== want.new_entry    ||
              result_payload.packed_color !== want.packed_color ||
              result_payload.overflow     !== want.overflow) begin
            fail_total++;
            if (fail_total <= 10) begin
              $display("%0t: mismatch: expected index %0d new %0b colour %h ovf %0b",
                       $realtime, want.color_index, want.new_entry,
                       want.packed_color, want.overflow);
              $display("%0t:           got      index %0d new %0b colour %h ovf %0b",
                       $realtime, result_payload.color_index, result_payload.new_entry,
                       result_payload.packed_color, result_payload.overflow);
            end
          end
        end
      end
    end
    outstanding <= expected_indices.size();
  end

endmodule

### verif/tb_rgb888_to_bgr555_palette_indexer.sv
// ----------------------------------------------------------------------------
// tb_rgb888_to_bgr555_palette_indexer
// Drives pixel streams shaped as images (small palettes with many repeats,
// and large ones that fill the palette and run into overflow) with random
// gaps on both channels and one long result stall; the checker does the
// comparing and this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_rgb888_to_bgr555_palette_indexer;

  timeunit 1ns;
  timeprecision 1ps;

  import rgbpal_pkg::*;

  localparam int unsigned PALETTE_DEPTH = 256;
  localparam int          PIXEL_ITEMS   = 1850;
  localparam int          IDLE_LIMIT    = 20000;
  localparam int          HOLD_AT       = 100;
  localparam int          HOLD_CYCLES   = 2000;
  localparam int          DRAIN_CYCLES  = PALETTE_DEPTH + 16;

  logic clk;
  logic rst = 1'b1;
  int   pixels_sent = 0;
  int   mismatches;
  int   outstanding;

  // first_pixel, blue, green, red
  pixel_t directed_pixels [16] = '{
    '{1'b1, 8'h00, 8'h00, 8'h00},  // empty palette, black goes in at 0
    '{1'b0, 8'hFF, 8'hFF, 8'hFF},
    '{1'b0, 8'h07, 8'h07, 8'h07},  // low bits only: hits black
    '{1'b0, 8'hF8, 8'hF8, 8'hF8},  // hits white
    '{1'b0, 8'hFF, 8'h00, 8'h00},
    '{1'b0, 8'h00, 8'hFF, 8'h00},
    '{1'b0, 8'h00, 8'h00, 8'hFF},
    '{1'b0, 8'hAA, 8'h55, 8'hAA},
    '{1'b0, 8'h55, 8'hAA, 8'h55},
    '{1'b0, 8'hAD, 8'h52, 8'hAF},
    '{1'b0, 8'h00, 8'h00, 8'hFF},
    '{1'b1, 8'h00, 8'h00, 8'hFF},  // new image mid-stream
    '{1'b1, 8'h00, 8'h00, 8'hFF},
    '{1'b0, 8'hFF, 8'hFF, 8'hFF},
    '{1'b0, 8'h00, 8'h00, 8'h07},
    '{1'b0, 8'h00, 8'h00, 8'h1F}
  };

  rgbpal_chan_if #(.payload_t(pixel_t))  pixel_ch ();
  rgbpal_chan_if #(.payload_t(result_t)) result_ch ();

  rgb888_to_bgr555_palette_indexer #(
    .PALETTE_DEPTH(PALETTE_DEPTH)
  ) dut (
    .clk    (clk),
    .rst    (rst),
    .pixel  (pixel_ch.sink),
    .result (result_ch.source)
  );

  rgbpal_palette_checker #(
    .PALETTE_DEPTH(PALETTE_DEPTH)
  ) palette_check (
    .clk            (clk),
    .rst            (rst),
    .pixel_valid    (pixel_ch.valid),
    .pixel_ready    (pixel_ch.ready),
    .pixel_payload  (pixel_ch.payload),
    .result_valid   (result_ch.valid),
    .result_ready   (result_ch.ready),
    .result_payload (result_ch.payload),
    .mismatches     (mismatches),
    .outstanding    (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap(input bit steady);
    int roll;
    if (steady) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // Random low bits under each channel so every input bit toggles.
  function automatic pixel_t dress_color(input bit first, input logic [COLOR_W-1:0] color);
    pixel_t px;
    px.first_pixel = first;
    px.blue        = {color[14:10], 3'($urandom_range(0, 7))};
    px.green       = {color[9:5],   3'($urandom_range(0, 7))};
    px.red         = {color[4:0],   3'($urandom_range(0, 7))};
    return px;
  endfunction

  // Called and returns at a falling edge; valid stays high between back-to-back requests.
  task automatic send_pixel(input pixel_t px, input int gap);
    if (gap > 0) begin
      pixel_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    pixel_ch.valid   <= 1'b1;
    pixel_ch.payload <= px;
    do @(posedge clk); while (!pixel_ch.ready);
    pixels_sent++;
    @(negedge clk);
  endtask

  task automatic send_image(input bit big, input bit marked);
    logic [COLOR_W-1:0] colors [$];
    logic [COLOR_W-1:0] base;
    logic [COLOR_W-1:0] stride;
    logic [COLOR_W-1:0] color;
    bit                 steady;
    bit                 first;
    int                 n_colors;
    int                 len;
    steady = ($urandom_range(0, 3) == 0);
    if (big) begin
      // odd stride gives PALETTE_DEPTH distinct colours, then a tail of hits and misses
      base   = 15'($urandom);
      stride = {14'($urandom), 1'b1};
      for (int i = 0; i < PALETTE_DEPTH; i++) begin
        colors.insert(colors.size(), base + 15'(i) * stride);
        if (i > 0 && $urandom_range(0, 9) == 0) begin
          send_pixel(dress_color(1'b0, colors[$urandom_range(0, i - 1)]), pick_gap(steady));
        end
        send_pixel(dress_color(i == 0 && marked, colors[i]), pick_gap(steady));
      end
      repeat ($urandom_range(16, 48)) begin
        if ($urandom_range(0, 1) == 1) begin
          color = colors[$urandom_range(0, PALETTE_DEPTH - 1)];
        end else begin
          color = 15'($urandom);
        end
        send_pixel(dress_color(1'b0, color), pick_gap(steady));
      end
    end else begin
      n_colors = $urandom_range(1, 24);
      repeat (n_colors) colors.insert(colors.size(), 15'($urandom));
      len = $urandom_range(4, 60);
      for (int i = 0; i < len; i++) begin
        first = (i == 0) ? marked : ($urandom_range(0, 99) == 0);
        send_pixel(dress_color(first, colors[$urandom_range(0, n_colors - 1)]),
                   pick_gap(steady));
      end
    end
  endtask

  initial begin : stimulus
    bit big;
    bit first_random;
    pixel_ch.valid   = 1'b0;
    pixel_ch.payload = '0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    foreach (directed_pixels[i]) begin
      send_pixel(directed_pixels[i], pick_gap(1'b0));
    end
    first_random = 1'b1;
    while (pixels_sent < PIXEL_ITEMS) begin
      big = first_random || ($urandom_range(0, 99) < 12);
      send_image(big, big || ($urandom_range(0, 9) != 0));
      first_random = 1'b0;
    end
    pixel_ch.valid <= 1'b0;
    wait (outstanding == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("[rgb888_to_bgr555_palette_indexer] OK");
    end else begin
      $display("[rgb888_to_bgr555_palette_indexer] ERROR");
    end
    $finish;
  end

  initial begin : result_sink
    bit held_off;
    int stall;
    result_ch.ready = 1'b0;
    held_off        = 1'b0;
    wait (!rst);
    @(negedge clk);
    forever begin
      if (!held_off && pixels_sent >= HOLD_AT) begin
        // long hold-off so the block backs up and stalls pixel requests
        result_ch.ready <= 1'b0;
        held_off = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if ($urandom_range(0, 7) == 0) begin
        result_ch.ready <= 1'b1;
        repeat ($urandom_range(50, 300)) @(negedge clk);
      end else begin
        stall = pick_gap(1'b0);
        if (stall > 0) begin
          result_ch.ready <= 1'b0;
          repeat (stall) @(negedge clk);
        end
        result_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst || (pixel_ch.valid && pixel_ch.ready) ||
          (result_ch.valid && result_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("[rgb888_to_bgr555_palette_indexer] ERROR");
    $finish;
  end

endmodule

### files.f
rtl/rgbpal_pkg.sv
rtl/rgbpal_chan_if.sv
rtl/rgbpal_mem.sv
rtl/rgbpal_seq.sv
rtl/rgb888_to_bgr555_palette_indexer.sv
verif/rgbpal_palette_checker.sv
verif/tb_rgb888_to_bgr555_palette_indexer.sv
